>>> design/rah_pkg.sv
package rah_pkg;

  localparam int FRACTION_BITS = 8;

  localparam int RH_W  = 14;
  localparam int TC_W  = 15;
  localparam int AH_W  = 16;

  localparam int A75_W     = 21;
  localparam int DEN_W     = 19;
  localparam int MAG_W     = 30;
  localparam int MAG_NUM_W = 47;
  localparam int RHK_W     = 28;
  localparam int DK_W      = 26;
  localparam int TCO_W     = 16;
  localparam int EXP_FRAC_BITS = 24;
  localparam int IPART_W   = MAG_W + 1 - EXP_FRAC_BITS;
  localparam int SH_W      = 8;
  localparam int Q_FRAC    = 30;
  localparam int P_W       = 31;
  localparam int NUM_W     = RHK_W + P_W;
  localparam int W_W       = NUM_W + 1;
  localparam int X_W       = W_W + 1;
  localparam int SHAMT_W   = 6;
  localparam int SHIFT_MAX = 37;
  localparam int D2_W      = DK_W + 1;

  localparam int S_BASE      = Q_FRAC - FRACTION_BITS;
  localparam int MAG_SCALE   = 75;
  localparam int DEN_BASE    = 237700;
  localparam int DEN_TC_MUL  = 10;
  localparam int RH_SCALE    = 12220;
  localparam int TC_OFFSET   = 27300;
  localparam int D_SCALE     = 923;
  localparam logic [25:0] LOG2_10_Q24 = 26'd55732705;

  typedef struct packed {
    logic             neg;
    logic [RHK_W-1:0] rhk;
    logic [DK_W-1:0]  dk;
  } rah_side_t;

  typedef struct packed {
    logic [SH_W-1:0]  shift;
    logic [RHK_W-1:0] rhk;
    logic [DK_W-1:0]  dk;
  } rah_pow_side_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    r   = '0;
    b   = 64'h4000_0000_0000_0000;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-(k+1)) in Q30, each entry the floor square root of the one before
  function automatic logic [P_W-1:0] pow_factor(input int k);
    logic [63:0] f;
    f = isqrt64(64'h2000_0000_0000_0000);
    for (int i = 0; i < k; i++) begin
      f = isqrt64(f << Q_FRAC);
    end
    return f[P_W-1:0];
  endfunction

endpackage

>>> design/rah_in_if.sv
interface rah_in_if;
  import rah_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [RH_W-1:0]        rel_humidity;
  logic signed [TC_W-1:0] temperature;

  modport source (output valid, output rel_humidity, output temperature, input ready);
  modport sink   (input valid, input rel_humidity, input temperature, output ready);
endinterface

>>> design/rah_out_if.sv
interface rah_out_if;
  import rah_pkg::*;
  logic            valid;
  logic            ready;
  logic [AH_W-1:0] abs_humidity;
  logic            saturated;

  modport source (output valid, output abs_humidity, output saturated, input ready);
  modport sink   (input valid, input abs_humidity, input saturated, output ready);
endinterface

>>> design/relative_to_absolute_humidity.sv
// channel | dir | payload                                   | handshake
// in_i    | in  | rel_humidity[13:0], temperature[14:0] s   | valid/ready
// out_o   | out | abs_humidity[15:0], saturated             | valid/ready
//
// One transaction enters per cycle while the pipe is not stalled; it passes through
// the 30-stage exponent divider, 24-stage power-of-two multiplier chain and
// the 16-stage final divider. All stages advance together whenever the
// output register is empty or taken, so a stall freezes the whole pipe.
// Reset clears only the stage valid bits.
module relative_to_absolute_humidity import rah_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rah_in_if.sink    in_i,
  rah_out_if.source out_o
);

  logic adv;
  logic out_valid_q;
  logic [AH_W-1:0] out_ah_q;
  logic out_sat_q;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // ---------------- stage 1: scale inputs
  logic signed [TC_W-1:0] tc;
  logic [TC_W-1:0]        tc_abs;
  logic signed [A75_W-1:0] den_s;
  logic signed [TCO_W:0]  tco;
  rah_side_t              s1_side_d;

  assign tc     = in_i.temperature;
  assign tc_abs = tc[TC_W-1] ? TC_W'(-tc) : TC_W'(tc);
  assign den_s  = A75_W'(DEN_BASE) + (A75_W'(tc) * A75_W'(DEN_TC_MUL));
  assign tco    = (TCO_W+1)'(tc) + (TCO_W+1)'(TC_OFFSET);
  assign s1_side_d.neg = tc[TC_W-1];
  assign s1_side_d.rhk = RHK_W'(in_i.rel_humidity) * RHK_W'(RH_SCALE);
  assign s1_side_d.dk  = DK_W'(tco[TCO_W-1:0]) * DK_W'(D_SCALE);

  logic             s1_v_q;
  logic [A75_W-1:0] s1_a75_q;
  logic [DEN_W-1:0] s1_den_q;
  rah_side_t        s1_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_a75_q  <= A75_W'(tc_abs) * A75_W'(MAG_SCALE);
      s1_den_q  <= den_s[DEN_W-1:0];
      s1_side_q <= s1_side_d;
    end
  end

  // ---------------- exponent divider: mag = round(75|t| log2(10) / den)
  logic             md_v_q    [0:MAG_W];
  logic [DEN_W-1:0] md_rem_q  [0:MAG_W];
  logic [MAG_W-1:0] md_lo_q   [0:MAG_W];
  logic [MAG_W-1:0] md_quo_q  [0:MAG_W];
  logic [DEN_W-1:0] md_den_q  [0:MAG_W];
  rah_side_t        md_side_q [0:MAG_W];

  logic [MAG_NUM_W-1:0] mnum;
  assign mnum = MAG_NUM_W'(s1_a75_q) * MAG_NUM_W'(LOG2_10_Q24)
              + MAG_NUM_W'(s1_den_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_v_q[0] <= 1'b0;
    end else if (adv) begin
      md_v_q[0] <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      md_rem_q[0]  <= DEN_W'(mnum[MAG_NUM_W-1:MAG_W]);
      md_lo_q[0]   <= mnum[MAG_W-1:0];
      md_quo_q[0]  <= '0;
      md_den_q[0]  <= s1_den_q;
      md_side_q[0] <= s1_side_q;
    end
  end

  for (genvar k = 0; k < MAG_W; k++) begin : g_mag
    logic [DEN_W:0] r2;
    logic           ge;
    logic [DEN_W:0] diff;
    assign r2   = {md_rem_q[k], md_lo_q[k][MAG_W-1]};
    assign ge   = r2 >= {1'b0, md_den_q[k]};
    assign diff = r2 - {1'b0, md_den_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        md_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        md_v_q[k+1] <= md_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        md_rem_q[k+1]  <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
        md_lo_q[k+1]   <= md_lo_q[k] << 1;
        md_quo_q[k+1]  <= {md_quo_q[k][MAG_W-2:0], ge};
        md_den_q[k+1]  <= md_den_q[k];
        md_side_q[k+1] <= md_side_q[k];
      end
    end
  end

  // ---------------- split exponent, 2^f chain
  logic [MAG_W:0]     y;
  logic [IPART_W-1:0] ipart;
  rah_pow_side_t      pw_side_d;
  assign y     = md_side_q[MAG_W].neg ? (~{1'b0, md_quo_q[MAG_W]} + 1'b1)
                                      : {1'b0, md_quo_q[MAG_W]};
  assign ipart = y[MAG_W:EXP_FRAC_BITS];
  assign pw_side_d.shift = SH_W'(S_BASE)
                         - {{(SH_W-IPART_W){ipart[IPART_W-1]}}, ipart};
  assign pw_side_d.rhk   = md_side_q[MAG_W].rhk;
  assign pw_side_d.dk    = md_side_q[MAG_W].dk;

  logic                     pw_v_q    [0:EXP_FRAC_BITS];
  logic [P_W-1:0]           pw_p_q    [0:EXP_FRAC_BITS];
  logic [EXP_FRAC_BITS-1:0] pw_f_q    [0:EXP_FRAC_BITS];
  rah_pow_side_t            pw_side_q [0:EXP_FRAC_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_v_q[0] <= 1'b0;
    end else if (adv) begin
      pw_v_q[0] <= md_v_q[MAG_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pw_p_q[0]    <= P_W'(1) << Q_FRAC;
      pw_f_q[0]    <= y[EXP_FRAC_BITS-1:0];
      pw_side_q[0] <= pw_side_d;
    end
  end

  for (genvar k = 0; k < EXP_FRAC_BITS; k++) begin : g_pow
    localparam logic [P_W-1:0] FACT = pow_factor(k);
    logic [2*P_W-1:0] prod;
    assign prod = (2*P_W)'(pw_p_q[k]) * (2*P_W)'(FACT)
                + ((2*P_W)'(1) << (Q_FRAC - 1));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pw_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        pw_v_q[k+1] <= pw_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        pw_p_q[k+1]    <= pw_f_q[k][EXP_FRAC_BITS-1-k] ? prod[Q_FRAC +: P_W] : pw_p_q[k];
        pw_f_q[k+1]    <= pw_f_q[k];
        pw_side_q[k+1] <= pw_side_q[k];
      end
    end
  end

  // ---------------- numerator product
  logic [SH_W-1:0]    sh_end;
  logic               nm_v_q;
  logic [NUM_W-1:0]   nm_num_q;
  logic [DK_W-1:0]    nm_dk_q;
  logic [SHAMT_W-1:0] nm_shamt_q;
  logic               nm_zero_q;
  logic               nm_neg_q;
  assign sh_end = pw_side_q[EXP_FRAC_BITS].shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm_v_q <= 1'b0;
    end else if (adv) begin
      nm_v_q <= pw_v_q[EXP_FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nm_num_q   <= NUM_W'(pw_side_q[EXP_FRAC_BITS].rhk) * NUM_W'(pw_p_q[EXP_FRAC_BITS]);
      nm_dk_q    <= pw_side_q[EXP_FRAC_BITS].dk;
      nm_shamt_q <= sh_end[SHAMT_W-1:0];
      nm_zero_q  <= $signed(sh_end) > $signed(SH_W'(SHIFT_MAX));
      nm_neg_q   <= sh_end[SH_W-1];
    end
  end

  // ---------------- scale down: w = 2*num >> s
  logic             wd_v_q;
  logic [W_W-1:0]   wd_w_q;
  logic [DK_W-1:0]  wd_dk_q;
  logic             wd_zero_q;
  logic             wd_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wd_v_q <= 1'b0;
    end else if (adv) begin
      wd_v_q <= nm_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wd_w_q    <= {nm_num_q, 1'b0} >> nm_shamt_q;
      wd_dk_q   <= nm_dk_q;
      wd_zero_q <= nm_zero_q || (nm_neg_q && nm_num_q == '0);
      wd_ovf_q  <= nm_neg_q && nm_num_q != '0;
    end
  end

  // ---------------- rounding add: result = (w + d) / 2d
  logic             xs_v_q;
  logic [X_W-1:0]   xs_x_q;
  logic [DK_W-1:0]  xs_dk_q;
  logic             xs_zero_q;
  logic             xs_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xs_v_q <= 1'b0;
    end else if (adv) begin
      xs_v_q <= wd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xs_x_q    <= X_W'(wd_w_q) + X_W'(wd_dk_q);
      xs_dk_q   <= wd_dk_q;
      xs_zero_q <= wd_zero_q;
      xs_ovf_q  <= wd_ovf_q;
    end
  end

  // ---------------- final divider, 16 quotient bits
  logic            qd_v_q    [0:AH_W];
  logic [D2_W-1:0] qd_rem_q  [0:AH_W];
  logic [AH_W-1:0] qd_lo_q   [0:AH_W];
  logic [AH_W-1:0] qd_quo_q  [0:AH_W];
  logic [D2_W-1:0] qd_d2_q   [0:AH_W];
  logic            qd_zero_q [0:AH_W];
  logic            qd_sat_q  [0:AH_W];

  logic sat_div;
  assign sat_div = xs_x_q[X_W-1:AH_W+1] >= (X_W-AH_W-1)'(xs_dk_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qd_v_q[0] <= 1'b0;
    end else if (adv) begin
      qd_v_q[0] <= xs_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      qd_rem_q[0]  <= xs_x_q[AH_W +: D2_W];
      qd_lo_q[0]   <= xs_x_q[AH_W-1:0];
      qd_quo_q[0]  <= '0;
      qd_d2_q[0]   <= {xs_dk_q, 1'b0};
      qd_zero_q[0] <= xs_zero_q;
      qd_sat_q[0]  <= xs_ovf_q || (!xs_zero_q && sat_div);
    end
  end

  for (genvar k = 0; k < AH_W; k++) begin : g_quo
    logic [D2_W:0] r2;
    logic          ge;
    logic [D2_W:0] diff;
    assign r2   = {qd_rem_q[k], qd_lo_q[k][AH_W-1]};
    assign ge   = r2 >= {1'b0, qd_d2_q[k]};
    assign diff = r2 - {1'b0, qd_d2_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        qd_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        qd_v_q[k+1] <= qd_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        qd_rem_q[k+1]  <= ge ? diff[D2_W-1:0] : r2[D2_W-1:0];
        qd_lo_q[k+1]   <= qd_lo_q[k] << 1;
        qd_quo_q[k+1]  <= {qd_quo_q[k][AH_W-2:0], ge};
        qd_d2_q[k+1]   <= qd_d2_q[k];
        qd_zero_q[k+1] <= qd_zero_q[k];
        qd_sat_q[k+1]  <= qd_sat_q[k];
      end
    end
  end

  // ---------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= qd_v_q[AH_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_sat_q <= qd_sat_q[AH_W];
      if (qd_sat_q[AH_W]) begin
        out_ah_q <= '1;
      end else if (qd_zero_q[AH_W]) begin
        out_ah_q <= '0;
      end else begin
        out_ah_q <= qd_quo_q[AH_W];
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.abs_humidity = out_ah_q;
  assign out_o.saturated    = out_sat_q;

  a_mag_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_v_q[MAG_W] |-> md_rem_q[MAG_W] < md_den_q[MAG_W])
    else $error("exponent divider remainder out of range");

  a_pow_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pw_v_q[EXP_FRAC_BITS] |-> pw_p_q[EXP_FRAC_BITS][P_W-1:Q_FRAC] == 1'b1)
    else $error("fractional power of two left [1,2)");

  a_quo_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qd_v_q[AH_W] && !qd_sat_q[AH_W] && !qd_zero_q[AH_W]
      |-> qd_rem_q[AH_W] < qd_d2_q[AH_W])
    else $error("final divider remainder out of range");

  a_sat_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_sat_q |-> out_ah_q == '1)
    else $error("saturated result not clamped");

endmodule
